// ===== src/bsm_pkg.sv =====
// Shared types, constants and helpers for the 3x3 box smoothing block.
// No dependencies; every other file imports this package.
package bsm_pkg;

    // Largest supported row length and the derived line-store widths.
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COL_W     = ADDR_W + 1;
    localparam int CFG_W     = 12;
    localparam int ROW_W     = CFG_W + 1;
    localparam int PIX_W     = 24;

    // Command queue depth between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Reciprocal of nine in 16 fractional bits, exact for sums up to 9 * 255.
    localparam int RECIP9     = 7282;
    localparam int RECIP_W    = 13;
    localparam int RECIP_SH   = 16;
    localparam int CSUM_W     = 10;
    localparam int WSUM_W     = 12;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Input request codes.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_pix_out;

    // Work item passed from the front to the back.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;      // column, also line-store address
        logic [PIX_W-1:0]  sample;    // {red, green, blue}, zero where masked
        logic              use_older; // row two above lies inside the frame
        logic              use_newer; // row one above lies inside the frame
        logic              col_zero;  // first column of a row
        logic              emit;      // this item yields a result
        logic              last;      // this result ends the frame
    } t_cmd;

    // Sum of one channel over a three-pixel column.
    function automatic logic [CSUM_W-1:0] col_sum(input logic [7:0] a,
                                                  input logic [7:0] b,
                                                  input logic [7:0] c);
        col_sum = CSUM_W'(a) + CSUM_W'(b) + CSUM_W'(c);
    endfunction

endpackage

// ===== src/bsm_front.sv =====
// Front end of the box smoother: configuration registers, input handshake
// and frame position tracking. Turns each input transaction into a t_cmd.
// Depends on bsm_pkg.
module bsm_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bsm_pkg::t_pix_in               i_in_data,
    output logic                           o_push,
    output bsm_pkg::t_cmd                  o_cmd,
    input  logic                           i_queue_full
);
    import bsm_pkg::*;

    logic [CFG_W-1:0]  r_frame_width, r_frame_height;
    logic [ADDR_W-1:0] r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  w_eff;
    logic [CFG_W-1:0]  h_eff;
    logic [ROW_W-1:0]  h_ext;
    logic              in_frame;
    logic [COL_W-1:0]  col_inc;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, width clamps to the line store.
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = COL_W'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(r_frame_width);
        end
        h_eff = (r_frame_height == '0) ? CFG_W'(1) : r_frame_height;
    end

    assign h_ext    = ROW_W'(h_eff);
    assign in_frame = (r_row < h_ext);
    assign col_inc  = COL_W'(r_col) + COL_W'(1);

    // Classify the incoming transaction.
    always_comb begin
        o_cmd.addr      = r_col;
        o_cmd.sample    = (i_in_data.req_type == REQ_PIXEL && in_frame)
                          ? {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in}
                          : '0;
        o_cmd.use_older = (r_row >= ROW_W'(2)) && ((r_row - ROW_W'(2)) < h_ext);
        o_cmd.use_newer = (r_row >= ROW_W'(1)) && ((r_row - ROW_W'(1)) < h_ext);
        o_cmd.col_zero  = (r_col == '0);
        o_cmd.emit      = (r_col == '0) ? (r_row >= ROW_W'(2)) : (r_row >= ROW_W'(1));
        o_cmd.last      = (r_col == '0) && (r_row >= ROW_W'(2))
                          && (r_row >= h_ext + ROW_W'(1));
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Advance the raster position; the frame-ending item restarts it.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (o_cmd.last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= w_eff) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = col_inc[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== src/bsm_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on bsm_pkg for the command type and depth.
module bsm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bsm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bsm_pkg::t_cmd o_cmd
);
    import bsm_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Storage slots carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue pop while empty");

endmodule

// ===== src/bsm_back.sv =====
// Back end of the box smoother: line store, window column sums, the
// divide by nine and the output register. Depends on bsm_pkg.
module bsm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  bsm_pkg::t_cmd      i_q_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bsm_pkg::t_pix_out  o_out_data
);
    import bsm_pkg::*;

    // Each line-store entry holds {older row, newer row}.
    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;

    logic               adv;
    logic               r_s1_valid;
    t_cmd               r_s1_cmd;
    logic               r_s1_fwd;
    logic [2*PIX_W-1:0] r_s1_fwd_data;
    logic [2*PIX_W-1:0] line_data;
    logic [2*PIX_W-1:0] wr_data;
    logic               s1_fire;
    logic [PIX_W-1:0]   c_older, c_newer;
    logic [CSUM_W-1:0]  cs [3];
    logic [CSUM_W-1:0]  r_cs1 [3];
    logic [CSUM_W-1:0]  r_cs2 [3];
    logic [WSUM_W-1:0]  wsum [3];

    logic               r_s2_valid;
    logic               r_s2_last;
    logic [WSUM_W-1:0]  r_s2_sum [3];
    logic [7:0]         quo [3];

    logic               r_out_valid;
    t_pix_out           r_out;

    // The whole back pipeline moves unless a result waits on a stalled receiver.
    assign adv     = !(r_out_valid && i_out_stall);
    assign o_pop   = adv && i_q_valid;
    assign s1_fire = adv && r_s1_valid;

    // Line-store read for the command at the queue head.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_line_mem[i_q_cmd.addr];
        end
    end

    // Line-store write as the command leaves stage one.
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_line_mem[r_s1_cmd.addr] <= wr_data;
        end
    end

    // Stage one control; a one-pixel row reads the entry being written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd      <= i_q_cmd;
            r_s1_fwd      <= r_s1_valid && (r_s1_cmd.addr == i_q_cmd.addr);
            r_s1_fwd_data <= wr_data;
        end
    end

    assign line_data = r_s1_fwd ? r_s1_fwd_data : r_rd_data;
    assign wr_data   = {line_data[PIX_W-1:0], r_s1_cmd.sample};
    assign c_older   = r_s1_cmd.use_older ? line_data[2*PIX_W-1:PIX_W] : '0;
    assign c_newer   = r_s1_cmd.use_newer ? line_data[PIX_W-1:0] : '0;

    // Column sums per channel and the window sum after the shift.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            cs[ch] = col_sum(c_older[8*(2-ch) +: 8], c_newer[8*(2-ch) +: 8],
                             r_s1_cmd.sample[8*(2-ch) +: 8]);
            wsum[ch] = WSUM_W'(r_cs1[ch]) + WSUM_W'(r_cs2[ch])
                       + (r_s1_cmd.col_zero ? '0 : WSUM_W'(cs[ch]));
        end
    end

    // Window: two retained column sums; a new row starts with an empty window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_cs1[ch] <= '0;
                r_cs2[ch] <= '0;
            end
        end else if (s1_fire) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (r_s1_cmd.last) begin
                    r_cs1[ch] <= '0;
                    r_cs2[ch] <= '0;
                end else if (r_s1_cmd.col_zero) begin
                    r_cs1[ch] <= '0;
                    r_cs2[ch] <= cs[ch];
                end else begin
                    r_cs1[ch] <= r_cs2[ch];
                    r_cs2[ch] <= cs[ch];
                end
            end
        end
    end

    // Stage two holds the window sums of emitting items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_last <= r_s1_cmd.last;
            for (int ch = 0; ch < 3; ch++) begin
                r_s2_sum[ch] <= wsum[ch];
            end
        end
    end

    // Divide by nine through a reciprocal multiply.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            quo[ch] = 8'(((WSUM_W+RECIP_W)'(r_s2_sum[ch])
                          * (WSUM_W+RECIP_W)'(RECIP9)) >> RECIP_SH);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid) begin
            r_out.red_out   <= quo[0];
            r_out.green_out <= quo[1];
            r_out.blue_out  <= quo[2];
            r_out.frame_end <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_s1_valid) && $stable(r_s2_valid)))
        else $error("pipeline moved under output stall");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_cmd.last) |-> r_s1_cmd.emit)
        else $error("frame end without a result");

endmodule

// ===== src/box_smoothing_3x3.sv =====
// Top level of the 3x3 box smoothing filter.
// Depends on bsm_pkg, bsm_front, bsm_queue and bsm_back.
//
// Pixels enter in raster order on the input channel (i_in_valid / o_in_stall);
// each transaction is accepted on a clock edge with valid high and stall low.
// Each pixel produces, per channel, floor of its 3x3 neighborhood sum over
// nine, with pixels outside the frame counted as zero. A result belongs to
// the pixel one row and one column before the transaction that produces it,
// so after the last pixel frame_width+1 flush transactions drain the frame;
// the last result carries frame_end and the block restarts at the top.
// A result leaves on o_out_valid once the transaction that produces it is accepted
// and has passed its steps in order (queue, line-store read, window sum, divide).
// One transaction is taken every cycle while the queue is not full; the line store
// is read as a command leaves the queue and written as it leaves stage one, in the
// same cycle as the next command's read, with a bypass for one-pixel rows.
// A stall on the output holds the result register and the back pipeline; the
// four-entry command queue keeps taking input until it fills.
// Reset clears position, window and pipeline and sets the frame size to
// 640 x 480; the line store needs no clearing pass.
// Frame size registers are written on the config channel; the user must write them only while idle, unenforced.
module box_smoothing_3x3 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bsm_pkg::t_pix_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bsm_pkg::t_pix_out              o_out_data
);
    import bsm_pkg::*;

    logic push, pop, q_full, q_valid;
    t_cmd push_cmd, q_cmd;

    // Front end: configuration and classification.
    bsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_queue_full (q_full)
    );

    // Command queue.
    bsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back end: line store, window and divide.
    bsm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== bench/tb_box_smoothing_3x3.sv =====
// Self-checking testbench for the 3x3 box smoothing filter.
// Depends on bsm_pkg and box_smoothing_3x3; its own model predicts each result unless a table row is typed.
module tb_box_smoothing_3x3;
    import bsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 420;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        t_pix_in          item;
        logic             typed;
        t_pix_out         result;
    } t_dir_row;

    localparam int DIR_ROWS = 20;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // Two by two frame of full-scale pixels: every result sees four of nine.
        '{12'd2, 12'd2, '{REQ_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{12'd2, 12'd2, '{REQ_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{12'd2, 12'd2, '{REQ_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{12'd2, 12'd2, '{REQ_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd113, 8'd113, 8'd113, 1'b0}},
        '{12'd2, 12'd2, '{REQ_FLUSH, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd113, 8'd113, 8'd113, 1'b0}},
        '{12'd2, 12'd2, '{REQ_FLUSH, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd113, 8'd113, 8'd113, 1'b0}},
        '{12'd2, 12'd2, '{REQ_FLUSH, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd113, 8'd113, 8'd113, 1'b1}},
        // One pixel frame; the second pixel lies past the last row and counts as a flush.
        '{12'd1, 12'd1, '{REQ_PIXEL, 8'd255, 8'd0, 8'd128}, 1'b0, '0},
        '{12'd1, 12'd1, '{REQ_PIXEL, 8'd0, 8'd255, 8'd7}, 1'b0, '0},
        '{12'd1, 12'd1, '{REQ_FLUSH, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd28, 8'd0, 8'd14, 1'b1}},
        // Three by two frame opening with a flush, which stands for a black pixel.
        '{12'd3, 12'd2, '{REQ_FLUSH, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{12'd3, 12'd2, '{REQ_PIXEL, 8'd1, 8'd2, 8'd3}, 1'b0, '0},
        '{12'd3, 12'd2, '{REQ_PIXEL, 8'd128, 8'd64, 8'd32}, 1'b0, '0},
        '{12'd3, 12'd2, '{REQ_PIXEL, 8'd255, 8'd254, 8'd127}, 1'b0, '0},
        '{12'd3, 12'd2, '{REQ_PIXEL, 8'd8, 8'd16, 8'd4}, 1'b0, '0},
        '{12'd3, 12'd2, '{REQ_PIXEL, 8'd200, 8'd100, 8'd50}, 1'b0, '0},
        '{12'd3, 12'd2, '{REQ_FLUSH, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{12'd3, 12'd2, '{REQ_FLUSH, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{12'd3, 12'd2, '{REQ_FLUSH, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{12'd3, 12'd2, '{REQ_FLUSH, 8'd0, 8'd0, 8'd0}, 1'b0, '0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_pix_in              i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_pix_out             o_out_data;

    // Filter model state.
    logic [CFG_W-1:0]     model_width = FRAME_WIDTH_RST;
    logic [CFG_W-1:0]     model_height = FRAME_HEIGHT_RST;
    logic [PIX_W-1:0]     older_line [MAX_WIDTH];
    logic [PIX_W-1:0]     newer_line [MAX_WIDTH];
    logic [PIX_W-1:0]     window [3][3];
    int                   pos_col = 0;
    int                   pos_row = 0;

    t_pix_out             pending_results [$];
    int                   error_count = 0;
    int                   pixels_sent = 0;
    int                   results_seen = 0;
    int                   frames_seen = 0;
    bit                   quiet = 1'b0;
    bit                   hold_request = 1'b0;
    int                   idle_cycles = 0;

    box_smoothing_3x3 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Average of the nine window pixels per channel, floor division.
    function automatic t_pix_out window_average(input logic last);
        t_pix_out res;
        int       sum [3];
        sum = '{0, 0, 0};
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                sum[0] += window[c][r][23:16];
                sum[1] += window[c][r][15:8];
                sum[2] += window[c][r][7:0];
            end
        end
        res.red_out   = 8'(sum[0] / 9);
        res.green_out = 8'(sum[1] / 9);
        res.blue_out  = 8'(sum[2] / 9);
        res.frame_end = last;
        return res;
    endfunction

    function automatic void clear_window();
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                window[c][r] = '0;
            end
        end
    endfunction

    // Advance the model by one accepted transaction; returns 1 when it yields a result.
    function automatic bit smooth_step(input t_pix_in it, output t_pix_out res);
        int               w, h, x, r;
        logic [PIX_W-1:0] sample, top, mid, bot;
        bit               last;
        w = (model_width == 0) ? 1 : ((model_width > MAX_WIDTH) ? MAX_WIDTH : model_width);
        h = (model_height == 0) ? 1 : model_height;
        x = pos_col % MAX_WIDTH;
        r = pos_row;
        res = '0;
        sample = (it.req_type == REQ_PIXEL && r < h) ?
                 {it.red_in, it.green_in, it.blue_in} : '0;
        top = (r >= 2 && r - 2 < h) ? older_line[x] : '0;
        mid = (r >= 1 && r - 1 < h) ? newer_line[x] : '0;
        bot = (r < h) ? sample : '0;
        older_line[x] = newer_line[x];
        newer_line[x] = sample;
        smooth_step = 1'b0;
        if (x == 0) begin
            if (r >= 2) begin
                // Right edge of the previous row: shift in an empty column.
                last = (r >= h + 1);
                window[0] = window[1];
                window[1] = window[2];
                window[2] = '{'0, '0, '0};
                res = window_average(last);
                smooth_step = 1'b1;
                if (last) begin
                    clear_window();
                    pos_col = 0;
                    pos_row = 0;
                    return smooth_step;
                end
            end
            clear_window();
            window[2] = '{top, mid, bot};
        end else begin
            window[0] = window[1];
            window[1] = window[2];
            window[2] = '{top, mid, bot};
            if (r >= 1) begin
                res = window_average(1'b0);
                smooth_step = 1'b1;
            end
        end
        x++;
        if (x >= w) begin
            x = 0;
            r++;
        end
        pos_col = x;
        pos_row = r;
    endfunction

    // Offer one pixel transaction, wait for acceptance and record its expected result.
    task automatic send_pixel(input t_pix_in it, input bit typed, input t_pix_out typed_res);
        t_pix_out res;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (smooth_step(it, res)) begin
            pending_results.push_back(typed ? typed_res : res);
        end
        pixels_sent++;
    endtask

    // Let the block drain completely before touching its registers.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH) model_width = val;
        else model_height = val;
        @(posedge i_clk);
    endtask

    task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // One full frame of random content plus its flush transactions, with occasional noise.
    task automatic send_frame();
        int       w, h;
        t_pix_in  it;
        w = (model_width == 0) ? 1 : ((model_width > MAX_WIDTH) ? MAX_WIDTH : model_width);
        h = (model_height == 0) ? 1 : model_height;
        for (int i = 0; i < w * h + w + 1; i++) begin
            it.red_in   = 8'($urandom);
            it.green_in = 8'($urandom);
            it.blue_in  = 8'($urandom);
            if (i < w * h) it.req_type = ($urandom_range(0, 19) == 0) ? REQ_FLUSH : REQ_PIXEL;
            else it.req_type = ($urandom_range(0, 19) == 0) ? REQ_PIXEL : REQ_FLUSH;
            send_pixel(it, 1'b0, '0);
        end
    endtask

    // Output stall: random bursts, one long hold on request, none at the end of the run.
    always @(posedge i_clk) begin
        if (hold_request) begin
            i_out_stall <= 1'b1;
            for (int n = 0; n < 300; n++) @(posedge i_clk);
            hold_request = 1'b0;
            i_out_stall <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_out_data.frame_end) frames_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction %h", o_out_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.red_out !== want.red_out) begin
                    $error("red_out expected %0d actual %0d", want.red_out, o_out_data.red_out);
                    error_count++;
                end
                if (o_out_data.green_out !== want.green_out) begin
                    $error("green_out expected %0d actual %0d",
                           want.green_out, o_out_data.green_out);
                    error_count++;
                end
                if (o_out_data.blue_out !== want.blue_out) begin
                    $error("blue_out expected %0d actual %0d", want.blue_out, o_out_data.blue_out);
                    error_count++;
                end
                if (o_out_data.frame_end !== want.frame_end) begin
                    $error("frame_end expected %0d actual %0d",
                           want.frame_end, o_out_data.frame_end);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d results outstanding", pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int random_start;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        clear_window();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; the frame size is rewritten when a group changes it.
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].width != model_width || DIR_TABLE[i].height != model_height) begin
                set_frame_size(DIR_TABLE[i].width, DIR_TABLE[i].height);
            end
            send_pixel(DIR_TABLE[i].item, DIR_TABLE[i].typed, DIR_TABLE[i].result);
        end

        // Size extremes: zero sizes, a single tall column, and a wider frame
        // that runs into a long output hold.
        set_frame_size(12'd0, 12'd0);
        send_frame();
        set_frame_size(12'd1, 12'd40);
        send_frame();
        set_frame_size(12'd64, 12'd3);
        hold_request = 1'b1;
        send_frame();

        // Random frames of small sizes; the last stretch runs without idling.
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_ITEMS) begin
            if (pixels_sent - random_start > RANDOM_ITEMS - 100) quiet = 1'b1;
            set_frame_size(12'($urandom_range(1, 12)), 12'($urandom_range(1, 6)));
            send_frame();
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end

        $display("Sent %0d pixel and flush transactions, checked %0d results over %0d frames,",
                 pixels_sent, results_seen, frames_seen);
        $display("including zero frame sizes, a single-column frame and a long output hold.");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/bsm_pkg.sv
src/bsm_front.sv
src/bsm_queue.sv
src/bsm_back.sv
src/box_smoothing_3x3.sv
bench/tb_box_smoothing_3x3.sv
